### sv/wmq_pkg.sv
// wavelet matrix query engine: shared constants, codes and types
// no dependencies; used by wavelet_matrix_query_engine
package wmq_pkg;

    localparam int MAX_LEN  = 1024;
    localparam int MAX_BITS = 16;
    localparam int SYM_W    = 16;
    localparam int IDX_W    = $clog2(MAX_LEN);
    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int LVL_W    = $clog2(MAX_BITS);
    localparam int HGT_W    = $clog2(MAX_BITS + 1);
    localparam int TOP_W    = $clog2(MAX_BITS + 1);
    localparam int CFG_W    = 5;
    localparam int K_W      = 11;

    typedef enum logic [1:0] {
        OP_LOAD     = 2'd0,
        OP_RANK     = 2'd1,
        OP_QUANTILE = 2'd2,
        OP_RANGE    = 2'd3
    } t_op;

    // range walk node: prefix counts a..b (inclusive start, exclusive end)
    typedef struct packed {
        logic [LEN_W-1:0] a;
        logic [LEN_W-1:0] b;
        logic [SYM_W-1:0] lo;
        logic [SYM_W-1:0] hi;
        logic [HGT_W-1:0] lv;
    } t_node;

endpackage

### sv/wavelet_matrix_query_engine.sv
// wavelet matrix query engine: load, build and rank / quantile / range count queries
// depends on wmq_pkg
//
// channel   dir  signals                        contents
// s         in   i_s_tvalid/o_s_tready          tuser operation, tlast last, tdata fields
// m         out  o_m_tvalid/i_m_tready          tdata answer, tuser valid_res
// cfg       in   i_cfg_wen/i_cfg_wdata          symbol_bits
//
// a load stores one symbol; the build makes a count pass and a partition pass per level
// over the work buffer memory, each element read then written; rank and quantile run
// S_Q_RA, S_Q_RB and S_Q_CALC per level (two rank memory reads and one update); range
// count runs S_R_EVAL plus those per visited inner node and S_R_EVAL alone per leaf node
// reset needs no clearing pass; a finished result waits in the output register while the
// next request is taken, a query finishing while it is still full stalls the engine
module wavelet_matrix_query_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: symbol[15:0] pos_i[25:16] pos_j[35:26] rank_k[46:36]
    //        value_lo[62:47] value_hi[78:63], zero fill above
    input  logic [79:0] i_s_tdata,
    // tuser: operation[1:0]
    input  logic [1:0]  i_s_tuser,
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: answer[15:0]
    output logic [15:0] o_m_tdata,
    // tuser: valid_res[0]
    output logic        o_m_tuser,
    input  logic        i_cfg_wen,
    input  logic [wmq_pkg::CFG_W-1:0] i_cfg_wdata
);

    localparam int LEN_W = wmq_pkg::LEN_W;
    localparam int IDX_W = wmq_pkg::IDX_W;
    localparam int LVL_W = wmq_pkg::LVL_W;
    localparam int HGT_W = wmq_pkg::HGT_W;
    localparam int TOP_W = wmq_pkg::TOP_W;
    localparam int SYM_W = wmq_pkg::SYM_W;
    localparam int K_W   = wmq_pkg::K_W;

    typedef enum logic [3:0] {
        S_IDLE, S_B1_RD, S_B1_WR, S_B2_RD, S_B2_WR,
        S_Q_RA, S_Q_RB, S_Q_CALC, S_R_EVAL, S_DONE
    } t_state;

    // memories
    logic [SYM_W-1:0] m_wbuf [2*wmq_pkg::MAX_LEN];
    logic [LEN_W-1:0] m_rank [wmq_pkg::MAX_BITS*wmq_pkg::MAX_LEN];

    t_state            r_state;
    logic [wmq_pkg::CFG_W-1:0] r_sbits;
    logic [HGT_W-1:0]  r_height;
    logic              r_built;
    logic [LEN_W-1:0]  r_len;
    logic              r_bank;
    logic [LEN_W-1:0]  r_zc [wmq_pkg::MAX_BITS];
    logic [LEN_W-1:0]  r_x;
    logic [LEN_W-1:0]  r_ones;
    logic [LEN_W-1:0]  r_zi;
    logic [LEN_W-1:0]  r_no;
    logic [LEN_W-1:0]  r_z;
    logic [HGT_W-1:0]  r_lv;
    logic [LVL_W-1:0]  r_sh;
    wmq_pkg::t_op      r_op;
    logic [LEN_W-1:0]  r_a;
    logic [LEN_W-1:0]  r_b;
    logic [K_W-1:0]    r_k;
    logic [SYM_W-1:0]  r_sym;
    logic [SYM_W-1:0]  r_elem;
    logic [SYM_W-1:0]  r_vlo;
    logic [SYM_W-1:0]  r_vhi;
    logic [SYM_W-1:0]  r_nlo;
    logic [SYM_W-1:0]  r_nhi;
    logic [LEN_W-1:0]  r_total;
    logic [LEN_W-1:0]  r_ra;
    wmq_pkg::t_node    r_stk [wmq_pkg::MAX_BITS];
    logic [TOP_W-1:0]  r_top;
    logic [SYM_W-1:0]  r_ans;
    logic              r_ok;
    logic              r_ovalid;
    logic [SYM_W-1:0]  r_odata;
    logic              r_ook;
    logic [SYM_W-1:0]  r_bdata;
    logic [LEN_W-1:0]  r_rdata;

    // request fields
    wmq_pkg::t_op      w_op;
    logic [SYM_W-1:0]  w_sym;
    logic [IDX_W-1:0]  w_pi;
    logic [IDX_W-1:0]  w_pj;
    logic [K_W-1:0]    w_k;
    logic [SYM_W-1:0]  w_vlo;
    logic [SYM_W-1:0]  w_vhi;

    assign w_op  = wmq_pkg::t_op'(i_s_tuser);
    assign w_sym = i_s_tdata[15:0];
    assign w_pi  = i_s_tdata[25:16];
    assign w_pj  = i_s_tdata[35:26];
    assign w_k   = i_s_tdata[46:36];
    assign w_vlo = i_s_tdata[62:47];
    assign w_vhi = i_s_tdata[78:63];

    logic              w_accept;
    logic [HGT_W-1:0]  w_eff_h;
    logic [LEN_W-1:0]  w_len0;
    logic [LEN_W-1:0]  w_pi1;
    logic [LEN_W-1:0]  w_pj1;
    logic [LEN_W-1:0]  w_span;
    logic              w_bit;
    logic [LEN_W-1:0]  w_rb;
    logic [LEN_W-1:0]  w_z;
    logic [LEN_W-1:0]  w_za;
    logic [LEN_W-1:0]  w_zb;
    logic [LEN_W-1:0]  w_oa;
    logic [LEN_W-1:0]  w_ob;
    logic [LEN_W-1:0]  w_qr;
    logic              w_go_one;
    logic [LEN_W-1:0]  w_na;
    logic [LEN_W-1:0]  w_nb;
    logic [SYM_W-1:0]  w_mid;
    logic              w_miss;
    logic              w_cover;
    logic [TOP_W-1:0]  w_top_m1;
    logic              w_bwen;
    logic [IDX_W:0]    w_bwaddr;
    logic [SYM_W-1:0]  w_bwdata;
    logic [IDX_W:0]    w_braddr;
    logic              w_rwen;
    logic [LVL_W+IDX_W-1:0] w_rwaddr;
    logic [LEN_W-1:0]  w_rwdata;
    logic [LVL_W+IDX_W-1:0] w_rraddr;
    logic [LEN_W-1:0]  w_dst;
    logic              w_rank_ok;
    logic              w_sym_fits;
    logic              w_quant_ok;
    logic              w_range_ok;

    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_eff_h  = (r_sbits == '0) ? HGT_W'(1) :
                      (r_sbits > wmq_pkg::CFG_W'(wmq_pkg::MAX_BITS)) ?
                      HGT_W'(wmq_pkg::MAX_BITS) : HGT_W'(r_sbits);
    assign w_len0   = r_built ? '0 : r_len;
    assign w_pi1    = {1'b0, w_pi} + LEN_W'(1);
    assign w_pj1    = {1'b0, w_pj} + LEN_W'(1);
    assign w_span   = w_pj1 - {1'b0, w_pi};

    assign w_rank_ok  = r_built && ({1'b0, w_pi} < r_len);
    // symbol wider than the height counts zero
    assign w_sym_fits = (({1'b0, w_sym} >> r_height) == '0);
    assign w_range_ok = r_built && ({1'b0, w_pj} < r_len) && (w_pi <= w_pj);
    assign w_quant_ok = w_range_ok && (w_k != '0) && (w_k <= w_span);

    assign w_bit    = r_bdata[r_sh];
    assign w_rb     = (r_b == '0) ? '0 : r_rdata;
    assign w_z      = r_zc[r_lv[LVL_W-1:0]];
    assign w_za     = r_a - r_ra;
    assign w_zb     = r_b - w_rb;
    assign w_oa     = w_z + r_ra;
    assign w_ob     = w_z + w_rb;
    assign w_qr     = w_zb - w_za;

    // branch choice for rank and quantile
    always_comb begin
        if (r_op == wmq_pkg::OP_RANK) begin
            w_go_one = r_sym[r_sh];
        end else begin
            w_go_one = (w_qr < r_k);
        end
        w_na = w_go_one ? w_oa : w_za;
        w_nb = w_go_one ? w_ob : w_zb;
    end

    assign w_mid    = r_nlo + ((r_nhi - r_nlo) >> 1);
    assign w_miss   = (r_vhi < r_nlo) || (r_nhi < r_vlo);
    assign w_cover  = (r_vlo <= r_nlo) && (r_nhi <= r_vhi);
    assign w_top_m1 = r_top - TOP_W'(1);
    assign w_dst    = w_bit ? (r_z + r_no) : r_zi;

    // memory port control
    always_comb begin
        w_bwen   = 1'b0;
        w_bwaddr = {r_bank, w_len0[IDX_W-1:0]};
        w_bwdata = w_sym;
        w_rwen   = 1'b0;
        w_rwaddr = {r_lv[LVL_W-1:0], r_x[IDX_W-1:0]};
        w_rwdata = r_ones + LEN_W'(w_bit);
        w_braddr = {r_bank, r_x[IDX_W-1:0]};
        w_rraddr = {r_lv[LVL_W-1:0], r_b[IDX_W-1:0] - IDX_W'(1)};
        if (r_state == S_IDLE && w_accept && w_op == wmq_pkg::OP_LOAD &&
            w_len0 < LEN_W'(wmq_pkg::MAX_LEN)) begin
            w_bwen = 1'b1;
        end
        if (r_state == S_B2_WR) begin
            w_bwen   = 1'b1;
            w_bwaddr = {~r_bank, w_dst[IDX_W-1:0]};
            w_bwdata = r_bdata;
        end
        if (r_state == S_B1_WR) begin
            w_rwen = 1'b1;
        end
        if (r_state == S_Q_RA) begin
            w_rraddr = {r_lv[LVL_W-1:0], r_a[IDX_W-1:0] - IDX_W'(1)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_bwen) begin
            m_wbuf[w_bwaddr] <= w_bwdata;
        end
        r_bdata <= m_wbuf[w_braddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_rwen) begin
            m_rank[w_rwaddr] <= w_rwdata;
        end
        r_rdata <= m_rank[w_rraddr];
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ook;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sbits  <= wmq_pkg::CFG_W'(8);
            r_height <= HGT_W'(8);
            r_built  <= 1'b0;
            r_len    <= '0;
            r_bank   <= 1'b0;
            r_top    <= '0;
            r_ovalid <= 1'b0;
            for (int n = 0; n < wmq_pkg::MAX_BITS; n++) begin
                r_zc[n] <= '0;
            end
        end else begin
            if (i_cfg_wen) begin
                r_sbits <= i_cfg_wdata;
            end
            if (i_m_tready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op    <= w_op;
                        r_sym   <= w_sym;
                        r_k     <= w_k;
                        r_vlo   <= w_vlo;
                        r_vhi   <= w_vhi;
                        r_lv    <= '0;
                        r_elem  <= '0;
                        r_total <= '0;
                        r_top   <= '0;
                        r_ans   <= '0;
                        r_nlo   <= '0;
                        r_nhi   <= SYM_W'((17'd1 << r_height) - 17'd1);
                        unique case (w_op)
                            wmq_pkg::OP_LOAD: begin
                                r_built <= 1'b0;
                                r_ok    <= 1'b0;
                                r_sh    <= LVL_W'(w_eff_h - HGT_W'(1));
                                r_a     <= {1'b0, w_pi};
                                r_b     <= w_pj1;
                                if (w_len0 < LEN_W'(wmq_pkg::MAX_LEN)) begin
                                    r_len <= w_len0 + LEN_W'(1);
                                end else begin
                                    r_len <= w_len0;
                                end
                                if (i_s_tlast) begin
                                    r_height <= w_eff_h;
                                    r_x      <= '0;
                                    r_ones   <= '0;
                                    r_state  <= S_B1_RD;
                                end else begin
                                    r_state <= S_IDLE;
                                end
                            end
                            wmq_pkg::OP_RANK: begin
                                r_sh    <= LVL_W'(r_height - HGT_W'(1));
                                r_ok    <= w_rank_ok;
                                r_a     <= '0;
                                r_b     <= w_pi1;
                                r_state <= (w_rank_ok && w_sym_fits) ? S_Q_RA : S_DONE;
                            end
                            wmq_pkg::OP_QUANTILE: begin
                                r_sh    <= LVL_W'(r_height - HGT_W'(1));
                                r_ok    <= w_quant_ok;
                                r_a     <= {1'b0, w_pi};
                                r_b     <= w_pj1;
                                r_state <= w_quant_ok ? S_Q_RA : S_DONE;
                            end
                            wmq_pkg::OP_RANGE: begin
                                r_sh    <= LVL_W'(r_height - HGT_W'(1));
                                r_ok    <= w_range_ok;
                                r_a     <= {1'b0, w_pi};
                                r_b     <= w_pj1;
                                r_state <= w_range_ok ? S_R_EVAL : S_DONE;
                            end
                            default: begin
                                r_sh    <= LVL_W'(r_height - HGT_W'(1));
                                r_ok    <= 1'b0;
                                r_a     <= {1'b0, w_pi};
                                r_b     <= w_pj1;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                // count pass: rank table and zero count of this level
                S_B1_RD: begin
                    if (r_x == r_len) begin
                        r_z                   <= r_len - r_ones;
                        r_zc[r_lv[LVL_W-1:0]] <= r_len - r_ones;
                        r_x                   <= '0;
                        r_zi                  <= '0;
                        r_no                  <= '0;
                        r_state               <= S_B2_RD;
                    end else begin
                        r_state <= S_B1_WR;
                    end
                end
                S_B1_WR: begin
                    r_ones  <= r_ones + LEN_W'(w_bit);
                    r_x     <= r_x + LEN_W'(1);
                    r_state <= S_B1_RD;
                end
                // stable zeros-first partition into the other bank
                S_B2_RD: begin
                    if (r_x == r_len) begin
                        r_bank <= ~r_bank;
                        r_lv   <= r_lv + HGT_W'(1);
                        r_sh   <= r_sh - LVL_W'(1);
                        r_x    <= '0;
                        r_ones <= '0;
                        if (r_lv + HGT_W'(1) == r_height) begin
                            r_built <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_B1_RD;
                        end
                    end else begin
                        r_state <= S_B2_WR;
                    end
                end
                S_B2_WR: begin
                    if (w_bit) begin
                        r_no <= r_no + LEN_W'(1);
                    end else begin
                        r_zi <= r_zi + LEN_W'(1);
                    end
                    r_x     <= r_x + LEN_W'(1);
                    r_state <= S_B2_RD;
                end
                S_Q_RA: begin
                    r_state <= S_Q_RB;
                end
                S_Q_RB: begin
                    r_ra    <= (r_a == '0) ? '0 : r_rdata;
                    r_state <= S_Q_CALC;
                end
                S_Q_CALC: begin
                    if (r_op == wmq_pkg::OP_RANGE) begin
                        r_stk[r_top[LVL_W-1:0]] <= '{a: w_oa, b: w_ob, lo: w_mid + SYM_W'(1),
                                                     hi: r_nhi, lv: r_lv + HGT_W'(1)};
                        r_top   <= r_top + TOP_W'(1);
                        r_a     <= w_za;
                        r_b     <= w_zb;
                        r_nhi   <= w_mid;
                        r_lv    <= r_lv + HGT_W'(1);
                        r_state <= S_R_EVAL;
                    end else begin
                        r_a  <= w_na;
                        r_b  <= w_nb;
                        r_lv <= r_lv + HGT_W'(1);
                        r_sh <= r_sh - LVL_W'(1);
                        if (w_go_one && r_op == wmq_pkg::OP_QUANTILE) begin
                            r_k    <= r_k - K_W'(w_qr);
                            r_elem <= r_elem | (SYM_W'(1) << r_sh);
                        end
                        if (r_lv + HGT_W'(1) == r_height) begin
                            if (r_op == wmq_pkg::OP_RANK) begin
                                r_ans <= SYM_W'(w_nb - w_na);
                            end else if (w_go_one) begin
                                r_ans <= r_elem | (SYM_W'(1) << r_sh);
                            end else begin
                                r_ans <= r_elem;
                            end
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_Q_RA;
                        end
                    end
                end
                S_R_EVAL: begin
                    if (w_miss || w_cover || r_lv >= r_height ||
                        r_top >= TOP_W'(wmq_pkg::MAX_BITS)) begin
                        if (!w_miss && w_cover && r_b >= r_a) begin
                            r_total <= r_total + (r_b - r_a);
                        end
                        if (r_top == '0) begin
                            r_ans <= SYM_W'(r_total) +
                                     ((!w_miss && w_cover && r_b >= r_a) ?
                                      SYM_W'(r_b - r_a) : SYM_W'(0));
                            r_state <= S_DONE;
                        end else begin
                            r_a     <= r_stk[w_top_m1[LVL_W-1:0]].a;
                            r_b     <= r_stk[w_top_m1[LVL_W-1:0]].b;
                            r_nlo   <= r_stk[w_top_m1[LVL_W-1:0]].lo;
                            r_nhi   <= r_stk[w_top_m1[LVL_W-1:0]].hi;
                            r_lv    <= r_stk[w_top_m1[LVL_W-1:0]].lv;
                            r_top   <= w_top_m1;
                        end
                    end else begin
                        r_state <= S_Q_RA;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= r_ans;
                        r_ook    <= r_ok;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // node stack never grows past one entry per level
    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= TOP_W'(wmq_pkg::MAX_BITS))
        else $error("node stack overflow");

    // an out-of-range query reports answer zero
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("nonzero answer on invalid query");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(wmq_pkg::MAX_LEN))
        else $error("sequence length overflow");

    // build passes stay inside the loaded length
    a_pass_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_B1_WR || r_state == S_B2_WR) |-> (r_x < r_len))
        else $error("build pass past length");

endmodule
